### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BSFO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSFO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bsfo_pkg.sv
// ---------------------------------------------------------------------------
// bsfo_pkg
// Types, widths and constants shared by the spectral flux onset unit.
// ---------------------------------------------------------------------------
package bsfo_pkg;

  localparam int NUM_BANDS     = 8;
  localparam int BAND_BINS_MAX = 512;

  localparam int BAND_W  = 3;
  localparam int OFFS_W  = 9;
  localparam int MAG_W   = 24;
  localparam int SUM_W   = MAG_W + 1;
  localparam int FLUX_W  = 34;
  localparam int BASE_W  = 50;
  localparam int CNT_W   = 8;
  localparam int ALPHA_W = 17;
  localparam int GAIN_W  = 8;

  localparam int MEM_DEPTH = NUM_BANDS * BAND_BINS_MAX;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int BSEL_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  // shared multiplier and accumulator
  localparam int FRAC_ALPHA = 16;
  localparam int THR_SHIFT  = 20;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = ALPHA_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = BASE_W + GAIN_W;
  localparam int THR_W      = ACC_W - THR_SHIFT + 1;

  localparam logic [ALPHA_W-1:0]    ALPHA_ONE      = ALPHA_W'(65536);
  localparam logic [ALPHA_W-1:0]    ALPHA_RST      = ALPHA_W'(1311);
  localparam logic [GAIN_W-1:0]     GAIN_RST       = GAIN_W'(64);
  localparam logic [MAG_W-1:0]      OFFSET_RST     = MAG_W'(12);
  localparam logic [CNT_W-1:0]      DEBOUNCE_RST   = CNT_W'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA    = 2'd0,
    CFG_GAIN     = 2'd1,
    CFG_OFFSET   = 2'd2,
    CFG_DEBOUNCE = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_DIFF,
    S_M_LO,
    S_M_H0,
    S_M_H1,
    S_STEP,
    S_BASE,
    S_M_G0,
    S_M_G1,
    S_THR,
    S_DECIDE
  } state_t;

  typedef enum logic [2:0] {
    MS_LO,
    MS_H0,
    MS_H1,
    MS_G0,
    MS_G1
  } mul_sel_t;

  typedef enum logic [2:0] {
    AO_HOLD,
    AO_LOAD_SH16,
    AO_ADD,
    AO_ADD_SH25,
    AO_LOAD
  } acc_op_t;

  typedef struct packed {
    logic     accept_en;
    logic     rmw;
    logic     clr_wr;
    logic     diff;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     base_wr;
    logic     decide;
  } cmd_t;

  typedef struct packed {
    logic in_ok;
    logic item_end;
    logic clr_last;
    logic out_busy;
  } status_t;

endpackage

### hdl/bsfo_ram.sv
// ---------------------------------------------------------------------------
// bsfo_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bsfo_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/bsfo_ctrl.sv
// ---------------------------------------------------------------------------
// bsfo_ctrl
// Sequencer: memory clear, bin read-modify-write, band-end arithmetic steps.
// ---------------------------------------------------------------------------
module bsfo_ctrl import bsfo_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (status.clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_tvalid && status.in_ok) state_nxt = S_RMW;
      S_RMW:    state_nxt = status.item_end ? S_DIFF : S_IDLE;
      S_DIFF:   state_nxt = S_M_LO;
      S_M_LO:   state_nxt = S_M_H0;
      S_M_H0:   state_nxt = S_M_H1;
      S_M_H1:   state_nxt = S_STEP;
      S_STEP:   state_nxt = S_BASE;
      S_BASE:   state_nxt = S_M_G0;
      S_M_G0:   state_nxt = S_M_G1;
      S_M_G1:   state_nxt = S_THR;
      S_THR:    state_nxt = S_DECIDE;
      S_DECIDE: if (!status.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MS_LO;
    cmd.acc_op  = AO_HOLD;
    unique case (state_r)
      S_CLEAR:  cmd.clr_wr    = 1'b1;
      S_IDLE:   cmd.accept_en = 1'b1;
      S_RMW:    cmd.rmw       = 1'b1;
      S_DIFF:   cmd.diff      = 1'b1;
      S_M_LO:   cmd.mul_sel   = MS_LO;
      S_M_H0: begin
        cmd.mul_sel = MS_H0;
        cmd.acc_op  = AO_LOAD_SH16;
      end
      S_M_H1: begin
        cmd.mul_sel = MS_H1;
        cmd.acc_op  = AO_ADD;
      end
      S_STEP:   cmd.acc_op    = AO_ADD_SH25;
      S_BASE:   cmd.base_wr   = 1'b1;
      S_M_G0:   cmd.mul_sel   = MS_G0;
      S_M_G1: begin
        cmd.mul_sel = MS_G1;
        cmd.acc_op  = AO_LOAD;
      end
      S_THR:    cmd.acc_op    = AO_ADD_SH25;
      S_DECIDE: cmd.decide    = !status.out_busy;
      default:  cmd.accept_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/bsfo_dp.sv
// ---------------------------------------------------------------------------
// bsfo_dp
// Datapath: magnitude memory, flux accumulator, shared multiplier, baseline
// and debounce registers, config registers, output register.
// ---------------------------------------------------------------------------
module bsfo_dp import bsfo_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  cmd_t                   cmd,
  output status_t                status
);

  // input fields
  logic [BAND_W-1:0] in_band;
  logic [OFFS_W-1:0] in_offs;
  logic [MAG_W-1:0]  in_ml, in_mr;
  logic              in_band_ok, in_offs_ok, accept;
  logic [ADDR_W-1:0] in_addr;

  assign in_band    = in_tdata[BAND_W-1:0];
  assign in_offs    = in_tdata[BAND_W +: OFFS_W];
  assign in_ml      = in_tdata[BAND_W+OFFS_W +: MAG_W];
  assign in_mr      = in_tdata[BAND_W+OFFS_W+MAG_W +: MAG_W];
  assign in_band_ok = 32'(in_band) < NUM_BANDS;
  assign in_offs_ok = 32'(in_offs) < BAND_BINS_MAX;
  assign accept     = in_tvalid & cmd.accept_en;
  assign in_addr    = ADDR_W'(in_band) * ADDR_W'(BAND_BINS_MAX) + ADDR_W'(in_offs);

  // control state
  logic [FLUX_W-1:0]  flux_r, flux_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               end_r, end_nxt;
  logic               offs_ok_r, offs_ok_nxt;
  logic [BASE_W-1:0]  baseline_r [NUM_BANDS];
  logic [BASE_W-1:0]  baseline_nxt [NUM_BANDS];
  logic [CNT_W-1:0]   debounce_r [NUM_BANDS];
  logic [CNT_W-1:0]   debounce_nxt [NUM_BANDS];
  logic [ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic [GAIN_W-1:0]  gain_r, gain_nxt;
  logic [MAG_W-1:0]   offset_r, offset_nxt;
  logic [CNT_W-1:0]   frames_r, frames_nxt;

  // payload
  logic [BAND_W-1:0]  band_r, band_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [SUM_W-1:0]   now_r, now_nxt;
  logic [BASE_W-1:0]  dmag_r, dmag_nxt;
  logic               neg_r, neg_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [BASE_W-1:0]  bnew_r, bnew_nxt;
  logic [BAND_W-1:0]  out_band_r, out_band_nxt;
  logic [FLUX_W-1:0]  out_flux_r, out_flux_nxt;
  logic               out_onset_r, out_onset_nxt;

  // datapath nets
  logic [BSEL_W-1:0]  bsel;
  logic [SUM_W-1:0]   prev, rise;
  logic [FLUX_W:0]    flux_add;
  logic [FLUX_W-1:0]  flux_sat;
  logic [BASE_W-1:0]  target, bcur, bnew_w;
  logic [ALPHA_W-1:0] alpha_clip;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [THR_W-1:0]   thr_w;
  logic [CNT_W-1:0]   cnt_cur, cnt_dec;
  logic               fire;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [SUM_W-1:0]   ram_wdata;

  assign bsel    = BSEL_W'(band_r);
  assign bcur    = baseline_r[bsel];
  assign cnt_cur = debounce_r[bsel];

  // previous magnitudes
  assign ram_we    = cmd.clr_wr | (cmd.rmw & offs_ok_r);
  assign ram_waddr = cmd.clr_wr ? clr_cnt_r : addr_r;
  assign ram_wdata = cmd.clr_wr ? '0 : now_r;

  bsfo_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MEM_DEPTH)
  ) u_mag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (prev)
  );

  assign rise     = (now_r > prev) ? now_r - prev : '0;
  assign flux_add = {1'b0, flux_r} + (FLUX_W+1)'(rise);
  assign flux_sat = flux_add[FLUX_W] ? '1 : flux_add[FLUX_W-1:0];

  assign target     = {flux_r, {FRAC_ALPHA{1'b0}}};
  assign alpha_clip = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign bnew_w     = neg_r ? bcur - acc_r[BASE_W-1:0] : bcur + acc_r[BASE_W-1:0];
  assign thr_w      = THR_W'(acc_r >> THR_SHIFT) + THR_W'(offset_r);
  assign cnt_dec    = (cnt_cur != '0) ? cnt_cur - 1'b1 : '0;
  assign fire       = (THR_W'(flux_r) > thr_w) && (cnt_dec == '0);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MS_LO: begin
        mul_a = MUL_A_W'(dmag_r[FRAC_ALPHA-1:0]);
        mul_b = alpha_clip;
      end
      MS_H0: begin
        mul_a = dmag_r[FRAC_ALPHA +: MUL_A_W];
        mul_b = alpha_clip;
      end
      MS_H1: begin
        mul_a = MUL_A_W'(dmag_r[BASE_W-1:FRAC_ALPHA+MUL_A_W]);
        mul_b = alpha_clip;
      end
      MS_G0: begin
        mul_a = bnew_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(gain_r);
      end
      MS_G1: begin
        mul_a = MUL_A_W'(bnew_r[BASE_W-1:MUL_A_W]);
        mul_b = MUL_B_W'(gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    acc_nxt = acc_r;
    case (cmd.acc_op)
      AO_LOAD_SH16: acc_nxt = ACC_W'(prod_r >> FRAC_ALPHA);
      AO_ADD:       acc_nxt = acc_r + ACC_W'(prod_r);
      AO_ADD_SH25:  acc_nxt = acc_r + (ACC_W'(prod_r) << MUL_A_W);
      AO_LOAD:      acc_nxt = ACC_W'(prod_r);
      default:      acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    band_nxt    = band_r;
    addr_nxt    = addr_r;
    now_nxt     = now_r;
    end_nxt     = end_r;
    offs_ok_nxt = offs_ok_r;
    if (accept) begin
      band_nxt    = in_band;
      addr_nxt    = in_addr;
      now_nxt     = SUM_W'(in_ml) + SUM_W'(in_mr);
      end_nxt     = in_tlast;
      offs_ok_nxt = in_offs_ok;
    end
  end

  always_comb begin
    flux_nxt = flux_r;
    if (cmd.rmw && offs_ok_r) flux_nxt = flux_sat;
    if (cmd.decide) flux_nxt = '0;
  end

  assign clr_cnt_nxt = cmd.clr_wr ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_comb begin
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    if (cmd.diff) begin
      if (target >= bcur) begin
        dmag_nxt = target - bcur;
        neg_nxt  = 1'b0;
      end else begin
        dmag_nxt = bcur - target;
        neg_nxt  = 1'b1;
      end
    end
  end

  always_comb begin
    baseline_nxt = baseline_r;
    bnew_nxt     = bnew_r;
    debounce_nxt = debounce_r;
    if (cmd.base_wr) begin
      baseline_nxt[bsel] = bnew_w;
      bnew_nxt           = bnew_w;
    end
    if (cmd.decide) begin
      debounce_nxt[bsel] = fire ? frames_r : cnt_dec;
    end
  end

  always_comb begin
    out_band_nxt  = out_band_r;
    out_flux_nxt  = out_flux_r;
    out_onset_nxt = out_onset_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    if (cmd.decide) begin
      out_band_nxt  = band_r;
      out_flux_nxt  = flux_r;
      out_onset_nxt = fire;
      out_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    alpha_nxt  = alpha_r;
    gain_nxt   = gain_r;
    offset_nxt = offset_r;
    frames_nxt = frames_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALPHA:    alpha_nxt  = cfg_data[ALPHA_W-1:0];
        CFG_GAIN:     gain_nxt   = cfg_data[GAIN_W-1:0];
        CFG_OFFSET:   offset_nxt = cfg_data[MAG_W-1:0];
        CFG_DEBOUNCE: frames_nxt = cfg_data[CNT_W-1:0];
        default:      alpha_nxt  = alpha_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flux_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      end_r       <= 1'b0;
      offs_ok_r   <= 1'b0;
      alpha_r     <= ALPHA_RST;
      gain_r      <= GAIN_RST;
      offset_r    <= OFFSET_RST;
      frames_r    <= DEBOUNCE_RST;
      for (int i = 0; i < NUM_BANDS; i++) begin
        baseline_r[i] <= '0;
        debounce_r[i] <= '0;
      end
    end else begin
      flux_r      <= flux_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      end_r       <= end_nxt;
      offs_ok_r   <= offs_ok_nxt;
      alpha_r     <= alpha_nxt;
      gain_r      <= gain_nxt;
      offset_r    <= offset_nxt;
      frames_r    <= frames_nxt;
      baseline_r  <= baseline_nxt;
      debounce_r  <= debounce_nxt;
    end
  end

  always_ff @(posedge clk) begin
    band_r      <= band_nxt;
    addr_r      <= addr_nxt;
    now_r       <= now_nxt;
    dmag_r      <= dmag_nxt;
    neg_r       <= neg_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    bnew_r      <= bnew_nxt;
    out_band_r  <= out_band_nxt;
    out_flux_r  <= out_flux_nxt;
    out_onset_r <= out_onset_nxt;
  end

  assign status.in_ok    = in_band_ok;
  assign status.item_end = end_r;
  assign status.clr_last = (clr_cnt_r == ADDR_W'(MEM_DEPTH - 1));
  assign status.out_busy = out_valid_r & ~out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_onset_r, out_flux_r, out_band_r});

endmodule

### hdl/band_spectral_flux_onset_unit.sv
// ---------------------------------------------------------------------------
// band_spectral_flux_onset_unit
// Per-band positive spectral flux with adaptive threshold onset flagging.
// ---------------------------------------------------------------------------
// One bin request at a time. For each bin the previous magnitude is read
// from the 4096 x 25 magnitude RAM, then the rise is accumulated and the new
// magnitude written back. For a bin marked tlast, the baseline step and the
// threshold then go through one shared 25x17 multiplier in five passes. The
// result sits in an output register, so the next bin is taken while it waits;
// a second band end stalls until it has been taken. After reset the unit
// zeroes the magnitude RAM with in_tready low; config writes are taken at any
// time.
module band_spectral_flux_onset_unit import bsfo_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] band_index, [11:3] bin_offset, [35:12] mag_left, [59:36] mag_right
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,   // band_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] band_out, [36:3] flux_sum, [37] onset
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t    cmd;
  status_t status;

  bsfo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .status    (status),
    .cmd       (cmd)
  );

  bsfo_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status)
  );

  assign in_tready = cmd.accept_en;
  assign cfg_ready = 1'b1;

endmodule

### hdl/bsfo_chk.sv
// ---------------------------------------------------------------------------
// bsfo_chk
// Port-level checks on the onset unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bsfo_chk import bsfo_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  `BSFO_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `BSFO_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed")
  `BSFO_ASSERT_IMP(a_result_gap, $rose(out_tvalid), !$past(in_tready), "result raced input")
  `BSFO_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind band_spectral_flux_onset_unit bsfo_chk u_chk (.*);
